[hdl/b64c_pkg.sv]
// Shared types, constants and character functions for the Base64 stream codec.
// No dependencies; imported by b64c_step and base64_stream_codec_core.
package b64c_pkg;

	localparam int MAX_RESULTS = 4;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       error_flag;
	} out_item_t;

	typedef struct packed {
		logic [23:0] group_bits;
		logic [1:0]  group_position;
		logic        pad_third;
		logic        pad_fourth;
		logic        discard_rest;
	} grp_state_t;

	// Map a 6-bit value to its alphabet character.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return 8'h41 + w;
		else if (v < 6'd52)
			return 8'h61 + (w - 8'd26);
		else if (v < 6'd62)
			return 8'h30 + (w - 8'd52);
		else if (v == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

	// Return {valid, value} for a character.
	function automatic logic [6:0] char_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end else if (c == 8'h2B) begin
			return {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

endpackage

[hdl/b64c_step.sv]
// One-item step of the codec: group state and item in, next state and burst out.
// Depends on b64c_pkg.
module b64c_step (
	input  logic                  decode_mode,
	input  b64c_pkg::grp_state_t  st,
	input  b64c_pkg::in_item_t    item,
	output b64c_pkg::grp_state_t  nxt,
	output logic [2:0]            n_res,
	output b64c_pkg::out_item_t [3:0] res
);
	import b64c_pkg::*;

	logic [1:0]  enc_pos;
	logic [23:0] enc_bits;
	logic [23:0] triple;
	logic [6:0]  dec_cv;
	logic        is_pad;
	logic [5:0]  dec_v;
	logic        dec_ok;
	logic [23:0] dec_bits;
	logic        pt;
	logic        pf;
	logic [1:0]  dec_cnt;

	always_comb begin
		enc_pos = (st.group_position > 2'd2) ? 2'd2 : st.group_position;
		enc_bits = {st.group_bits[15:0], item.data_byte};
		unique case (enc_pos)
			2'd0:    triple = {enc_bits[7:0], 16'h0000};
			2'd1:    triple = {enc_bits[15:0], 8'h00};
			default: triple = enc_bits;
		endcase
		dec_cv = char_value(item.data_byte);
		is_pad = (item.data_byte == PAD_CHAR);
		dec_v = is_pad ? 6'd0 : dec_cv[5:0];
		dec_ok = is_pad || dec_cv[6];
		dec_bits = {st.group_bits[17:0], dec_v};
		pt = st.pad_third | (is_pad && st.group_position == 2'd2);
		pf = st.pad_fourth | (is_pad && st.group_position == 2'd3);
		dec_cnt = item.last_in ? (2'd3 - ({1'b0, pt} + {1'b0, pf})) : 2'd3;
	end

	always_comb begin
		nxt = st;
		n_res = 3'd0;
		res = '0;
		if (!decode_mode) begin
			if (enc_pos < 2'd2 && !item.last_in) begin
				nxt.group_bits = enc_bits;
				nxt.group_position = enc_pos + 2'd1;
			end else begin
				for (int k = 0; k < MAX_RESULTS; k++) begin
					res[k].out_byte = (k < int'(enc_pos) + 2) ?
						enc_char(triple[23 - 6 * k -: 6]) : PAD_CHAR;
					res[k].out_last = (k == MAX_RESULTS - 1) && item.last_in;
					res[k].error_flag = 1'b0;
				end
				n_res = 3'd4;
				nxt.group_bits = '0;
				nxt.group_position = 2'd0;
				nxt.pad_third = 1'b0;
				nxt.pad_fourth = 1'b0;
			end
		end else if (st.discard_rest) begin
			if (item.last_in) begin
				nxt = '0;
			end
		end else if (!dec_ok || (st.group_position != 2'd3 && item.last_in)) begin
			res[0].out_byte = 8'h00;
			res[0].out_last = 1'b1;
			res[0].error_flag = 1'b1;
			n_res = 3'd1;
			nxt = '0;
			nxt.discard_rest = !dec_ok && !item.last_in;
		end else if (st.group_position != 2'd3) begin
			nxt.group_bits = dec_bits;
			nxt.group_position = st.group_position + 2'd1;
			nxt.pad_third = pt;
			nxt.pad_fourth = pf;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (k < int'(dec_cnt)) begin
					res[k].out_byte = dec_bits[23 - 8 * k -: 8];
					res[k].out_last = (k + 1 == int'(dec_cnt)) && item.last_in;
					res[k].error_flag = 1'b0;
				end
			end
			n_res = {1'b0, dec_cnt};
			nxt = '0;
		end
	end

endmodule

[hdl/base64_stream_codec_core.sv]
// Top level of the Base64 stream codec: input register, step logic, result burst.
// Depends on b64c_pkg and b64c_step.
//
// Usage:
//   byte channel (byte_valid / byte_stall / byte_item): one byte or character
//     per item, last_in marks the end of a message.
//   res channel (res_valid / res_stall / res_item): one character or byte per
//     item; error items carry out_byte 0, out_last 1, error_flag 1.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): decode_mode, 0 encode,
//     1 decode. Always ready; a write clears all group state. Write only idle.
// Result path: an accepted item is held in the input register, and its
//   results are then loaded into the result register, which presents them.
// Throughput: an item that completes a group loads its burst (up to four
//   results) into the result register; the burst drains one result per
//   cycle while res_stall is low, so encoding is limited by the drain of the
//   burst, and decoding takes one character per cycle, set by the input.
//   Items that give no result never wait for a busy result burst.
// Reset: encode mode, empty group, nothing pending.
// Stall: a stalled result holds; the input stalls once the input register
//   holds an item that cannot enter a busy result burst.
module base64_stream_codec_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  b64c_pkg::in_item_t   byte_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output b64c_pkg::out_item_t  res_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);
	import b64c_pkg::*;

	logic                 s1_v_q;
	in_item_t             item_s1;
	logic                 mode_q;
	grp_state_t           st_q;
	grp_state_t           st_n;
	logic [2:0]           n_res;
	out_item_t [3:0]      res_n;
	out_item_t [3:0]      res_q;
	logic [2:0]           cnt_q;
	logic                 res_free;
	logic                 move;
	logic                 load;
	logic                 take;
	logic                 cfg_wr;

	b64c_step u_step (
		.decode_mode (mode_q),
		.st          (st_q),
		.item        (item_s1),
		.nxt         (st_n),
		.n_res       (n_res),
		.res         (res_n)
	);

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign res_valid = (cnt_q != 3'd0);
	assign take = res_valid && !res_stall;
	assign res_free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && !res_stall);
	assign move = s1_v_q && (res_free || n_res == 3'd0);
	assign load = move && n_res != 3'd0;
	assign byte_stall = s1_v_q && !move;
	assign res_item = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (!byte_stall) begin
			s1_v_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			st_q <= '0;
		end else if (cfg_wr) begin
			mode_q <= cfg_data;
			st_q <= '0;
		end else if (move) begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= n_res;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_n;
		end else if (take) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result burst count out of range");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> !byte_stall)
		else $error("input stalled with empty input register");

	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.error_flag |-> res_item.out_last && res_item.out_byte == 8'h00)
		else $error("malformed error item");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> st_q.group_position == 2'd0 && !st_q.discard_rest && mode_q == $past(cfg_data))
		else $error("configuration write did not reset group state");

endmodule
